// ----- hdl/c3p_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c3p_pkg: shared widths, types and helpers
// Widths of the circumcircle datapath, cell word types and the status codes.
// ----------------------------------------------------------------------------
package c3p_pkg;

    localparam int CW   = 32;          // coordinate width
    localparam int DFW  = CW + 1;      // coordinate difference
    localparam int SQW  = 2 * CW;      // squared norm
    localparam int HW   = CW;          // half of a squared norm
    localparam int PW   = 2 * CW + 1;  // coordinate times difference
    localparam int PPW  = 2 * DFW;     // partial product
    localparam int DETW = 2 * CW + 4;  // determinant
    localparam int NUMW = 3 * CW + 4;  // centre numerator
    localparam int QB   = CW + 2;      // quotient bits
    localparam int REMW = DETW;        // divider remainder and divisor
    localparam int DXW  = QB + 2;      // offset from first point
    localparam int MAGW = CW - 1;      // offset magnitude and radius
    localparam int RADW = 2 * CW;      // radicand
    localparam int RTW  = CW;          // root
    localparam int SRW  = CW + 3;      // root remainder

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COLIN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic          valid;
        logic          colin;
        logic          negx;
        logic          negy;
        logic          ovfx;
        logic          ovfy;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } t_dtag;

    typedef struct packed {
        logic [REMW-1:0] remx;
        logic [REMW-1:0] remy;
        logic [QB-1:0]   nlx;
        logic [QB-1:0]   nly;
        logic [QB-1:0]   qx;
        logic [QB-1:0]   qy;
        logic [REMW-1:0] dm;
    } t_ddat;

    typedef struct packed {
        logic          valid;
        logic          colin;
        logic          sat;
        logic          big;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
    } t_stag;

    typedef struct packed {
        logic [RADW-1:0] rad;
        logic [SRW-1:0]  rem;
        logic [RTW-1:0]  root;
    } t_sdat;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [REMW:0] div_step(input logic [REMW-1:0] rem,
                                               input logic b,
                                               input logic [REMW-1:0] dm);
        logic [REMW:0] t;
        logic          ge;
        t  = {rem, b};
        ge = (t >= {1'b0, dm});
        if (ge) begin
            return {1'b1, REMW'(t - {1'b0, dm})};
        end
        return {1'b0, t[REMW-1:0]};
    endfunction

    // saturated centre coordinate: {saturated, value}
    function automatic logic [CW:0] sat_cen(input logic [QB-1:0] q, input logic neg,
                                            input logic ovf);
        logic          sat;
        logic [CW-1:0] v;
        logic [QB-1:0] lim;
        lim = QB'(1) << (CW - 1);
        if (ovf) begin
            sat = 1'b1;
        end else if (neg) begin
            sat = (q > lim);
        end else begin
            sat = (q >= lim);
        end
        if (sat) begin
            v = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            v = neg ? CW'(QB'(0) - q) : q[CW-1:0];
        end
        return {sat, v};
    endfunction

    // point coordinate minus signed quotient
    function automatic logic [DXW-1:0] delta(input logic [CW-1:0] p, input logic [QB-1:0] q,
                                             input logic neg);
        logic [DXW-1:0] qe;
        logic [DXW-1:0] c;
        logic [DXW-1:0] pe;
        qe = DXW'(q);
        c  = neg ? (DXW'(0) - qe) : qe;
        pe = {{(DXW-CW){p[CW-1]}}, p};
        return pe - c;
    endfunction

    // {too big, magnitude}
    function automatic logic [MAGW:0] mag_of(input logic [DXW-1:0] d);
        logic           fits;
        logic           big;
        logic [DXW-1:0] a;
        fits = (d[DXW-1:CW-1] == '0) || (d[DXW-1:CW-1] == '1);
        big  = !fits || (d[CW-1:0] == {1'b1, {(CW-1){1'b0}}});
        a    = d[DXW-1] ? (DXW'(0) - d) : d;
        return {big, a[MAGW-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/c3p_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c3p_front: determinant and numerator pipeline
// Six stages: differences, squares, sums, split products, numerators and
// magnitudes, then the divider start word.
// ----------------------------------------------------------------------------
module c3p_front import c3p_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW-1:0] i_first_x,
    input  wire logic signed [CW-1:0] i_first_y,
    input  wire logic signed [CW-1:0] i_second_x,
    input  wire logic signed [CW-1:0] i_second_y,
    input  wire logic signed [CW-1:0] i_third_x,
    input  wire logic signed [CW-1:0] i_third_y,
    output t_dtag                     o_tag,
    output t_ddat                     o_dat
);

    logic                   r_v [6];

    logic signed [CW-1:0]   r1_x [3];
    logic signed [CW-1:0]   r1_y [3];
    logic signed [DFW-1:0]  r1_t [3];
    logic signed [DFW-1:0]  r1_u [3];

    logic signed [SQW-1:0]  r2_xx [3];
    logic signed [SQW-1:0]  r2_yy [3];
    logic signed [PW-1:0]   r2_p [3];
    logic signed [DFW-1:0]  r2_t [3];
    logic signed [DFW-1:0]  r2_u [3];
    logic [CW-1:0]          r2_x1, r2_y1;

    logic [SQW-1:0]         r3_s [3];
    logic signed [DETW-1:0] r3_d;
    logic signed [DFW-1:0]  r3_t [3];
    logic signed [DFW-1:0]  r3_u [3];
    logic [CW-1:0]          r3_x1, r3_y1;

    logic signed [PPW-1:0]  r4_ah [3];
    logic signed [PPW-1:0]  r4_al [3];
    logic signed [PPW-1:0]  r4_bh [3];
    logic signed [PPW-1:0]  r4_bl [3];
    logic signed [DETW-1:0] r4_d;
    logic [CW-1:0]          r4_x1, r4_y1;

    logic signed [NUMW-1:0] r5_nx, r5_ny;
    logic signed [DETW-1:0] r5_d;
    logic [CW-1:0]          r5_x1, r5_y1;

    logic signed [NUMW-1:0] n5_nx, n5_ny;
    logic [NUMW-1:0]        n6_mx, n6_my;
    logic [REMW-1:0]        n6_dm;
    t_dtag                  r_tag, n_tag;
    t_ddat                  r_dat, n_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < 6; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_comb begin
        n5_nx = (r4_ah[0] <<< HW) + (r4_ah[1] <<< HW) + (r4_ah[2] <<< HW)
              + r4_al[0] + r4_al[1] + r4_al[2];
        n5_ny = (r4_bh[0] <<< HW) + (r4_bh[1] <<< HW) + (r4_bh[2] <<< HW)
              + r4_bl[0] + r4_bl[1] + r4_bl[2];
        n6_mx = r5_nx[NUMW-1] ? NUMW'(-r5_nx) : NUMW'(r5_nx);
        n6_my = r5_ny[NUMW-1] ? NUMW'(-r5_ny) : NUMW'(r5_ny);
        n6_dm = r5_d[DETW-1] ? REMW'(-r5_d) : REMW'(r5_d);
        n_tag.valid = r_v[4];
        n_tag.colin = (r5_d == '0);
        n_tag.negx  = r5_nx[NUMW-1] ^ r5_d[DETW-1];
        n_tag.negy  = r5_ny[NUMW-1] ^ r5_d[DETW-1];
        n_tag.ovfx  = ((n6_mx >> QB) >= NUMW'(n6_dm));
        n_tag.ovfy  = ((n6_my >> QB) >= NUMW'(n6_dm));
        n_tag.x1    = r5_x1;
        n_tag.y1    = r5_y1;
        n_dat.remx  = REMW'(n6_mx >> QB);
        n_dat.remy  = REMW'(n6_my >> QB);
        n_dat.nlx   = n6_mx[QB-1:0];
        n_dat.nly   = n6_my[QB-1:0];
        n_dat.qx    = '0;
        n_dat.qy    = '0;
        n_dat.dm    = n6_dm;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x[0] <= i_first_x;
            r1_x[1] <= i_second_x;
            r1_x[2] <= i_third_x;
            r1_y[0] <= i_first_y;
            r1_y[1] <= i_second_y;
            r1_y[2] <= i_third_y;
            r1_t[0] <= i_second_y - i_third_y;
            r1_t[1] <= i_third_y - i_first_y;
            r1_t[2] <= i_first_y - i_second_y;
            r1_u[0] <= i_third_x - i_second_x;
            r1_u[1] <= i_first_x - i_third_x;
            r1_u[2] <= i_second_x - i_first_x;

            for (int i = 0; i < 3; i++) begin
                r2_xx[i] <= r1_x[i] * r1_x[i];
                r2_yy[i] <= r1_y[i] * r1_y[i];
                r2_p[i]  <= r1_x[i] * r1_t[i];
                r2_t[i]  <= r1_t[i];
                r2_u[i]  <= r1_u[i];
            end
            r2_x1 <= r1_x[0];
            r2_y1 <= r1_y[0];

            for (int i = 0; i < 3; i++) begin
                r3_s[i] <= SQW'(r2_xx[i] + r2_yy[i]);
                r3_t[i] <= r2_t[i];
                r3_u[i] <= r2_u[i];
            end
            r3_d  <= (r2_p[0] + r2_p[1] + r2_p[2]) <<< 1;
            r3_x1 <= r2_x1;
            r3_y1 <= r2_y1;

            for (int i = 0; i < 3; i++) begin
                r4_ah[i] <= $signed({1'b0, r3_s[i][SQW-1:HW]}) * r3_t[i];
                r4_al[i] <= $signed({1'b0, r3_s[i][HW-1:0]}) * r3_t[i];
                r4_bh[i] <= $signed({1'b0, r3_s[i][SQW-1:HW]}) * r3_u[i];
                r4_bl[i] <= $signed({1'b0, r3_s[i][HW-1:0]}) * r3_u[i];
            end
            r4_d  <= r3_d;
            r4_x1 <= r3_x1;
            r4_y1 <= r3_y1;

            r5_nx <= n5_nx;
            r5_ny <= n5_ny;
            r5_d  <= r4_d;
            r5_x1 <= r4_x1;
            r5_y1 <= r4_y1;

            r_dat <= n_dat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= n_tag;
        end
    end

    assign o_tag = r_tag;
    assign o_dat = r_dat;

endmodule
`default_nettype wire

// ----- hdl/c3p_div_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c3p_div_cell: one quotient bit of both centre divisions
// Shift in the next numerator bit, compare with the divisor, subtract.
// ----------------------------------------------------------------------------
module c3p_div_cell import c3p_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_dtag i_tag,
    input  wire t_ddat i_dat,
    output t_dtag      o_tag,
    output t_ddat      o_dat
);

    t_dtag           r_tag;
    t_ddat           r_dat, n_dat;
    logic [REMW:0]   w_sx, w_sy;

    always_comb begin
        w_sx        = div_step(i_dat.remx, i_dat.nlx[QB-1], i_dat.dm);
        w_sy        = div_step(i_dat.remy, i_dat.nly[QB-1], i_dat.dm);
        n_dat.remx  = w_sx[REMW-1:0];
        n_dat.remy  = w_sy[REMW-1:0];
        n_dat.nlx   = {i_dat.nlx[QB-2:0], 1'b0};
        n_dat.nly   = {i_dat.nly[QB-2:0], 1'b0};
        n_dat.qx    = {i_dat.qx[QB-2:0], w_sx[REMW]};
        n_dat.qy    = {i_dat.qy[QB-2:0], w_sy[REMW]};
        n_dat.dm    = i_dat.dm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dat <= n_dat;
        end
    end

    assign o_tag = r_tag;
    assign o_dat = r_dat;

endmodule
`default_nettype wire

// ----- hdl/c3p_sqrt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c3p_sqrt_cell: one root bit of the radius square root
// Bring down two radicand bits, try the next root bit, keep the remainder.
// ----------------------------------------------------------------------------
module c3p_sqrt_cell import c3p_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_stag i_tag,
    input  wire t_sdat i_dat,
    output t_stag      o_tag,
    output t_sdat      o_dat
);

    t_stag           r_tag;
    t_sdat           r_dat, n_dat;
    logic [SRW+1:0]  w_t, w_try;
    logic            w_ge;

    always_comb begin
        w_t        = {i_dat.rem, i_dat.rad[RADW-1:RADW-2]};
        w_try      = (SRW+2)'({i_dat.root, 2'b01});
        w_ge       = (w_t >= w_try);
        n_dat.rem  = w_ge ? SRW'(w_t - w_try) : w_t[SRW-1:0];
        n_dat.root = {i_dat.root[RTW-2:0], w_ge};
        n_dat.rad  = {i_dat.rad[RADW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dat <= n_dat;
        end
    end

    assign o_tag = r_tag;
    assign o_dat = r_dat;

endmodule
`default_nettype wire

// ----- hdl/circle_through_three_points.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circle_through_three_points: circumcircle of a point triple
// Centre and radius of the circle through three signed fixed point points.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with the six coordinates; a word is taken
// at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with centre, radius and status.
// The pipeline is a fixed chain: six front stages, 34 divider cells (one
// quotient bit each, both centre coordinates side by side), three offset and
// square stages, 32 square root cells (one root bit each) and the output
// register. A word passes down the chain in that order, and one word is
// taken in every cycle in which o_stall is low.
// While the output word waits under i_stall, the whole chain holds and
// o_stall is high; with no word waiting o_stall is low.
// Reset clears all valid flags; the chain comes up empty and ready.
// Collinear points give a zero centre and radius with the collinear status;
// a centre or radius that does not fit is clamped and flagged.
// ----------------------------------------------------------------------------
module circle_through_three_points import c3p_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [CW-1:0] i_first_x,
    input  wire logic signed [CW-1:0] i_first_y,
    input  wire logic signed [CW-1:0] i_second_x,
    input  wire logic signed [CW-1:0] i_second_y,
    input  wire logic signed [CW-1:0] i_third_x,
    input  wire logic signed [CW-1:0] i_third_y,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [CW-1:0]      o_centre_x,
    output logic signed [CW-1:0]      o_centre_y,
    output logic [MAGW-1:0]           o_radius,
    output logic [1:0]                o_status
);

    logic            w_en;
    t_dtag           d_tag [QB+1];
    t_ddat           d_dat [QB+1];
    t_stag           s_tag [RTW+1];
    t_sdat           s_dat [RTW+1];

    t_stag           r_p1, r_p2, r_p3, n_p1, n_p2;
    logic [DXW-1:0]  r_p1_dx, r_p1_dy;
    logic [2*MAGW-1:0] r_p2_sx, r_p2_sy;
    logic [RADW-1:0] r_p3_v;
    logic [CW:0]     w_cx, w_cy;
    logic [MAGW:0]   w_mx, w_my;

    logic            r_out_valid;
    logic [CW-1:0]   r_cx, r_cy;
    logic [MAGW-1:0] r_rad;
    t_status         r_st;
    logic            w_big;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    c3p_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .o_tag      (d_tag[0]),
        .o_dat      (d_dat[0])
    );

    for (genvar k = 0; k < QB; k++) begin : g_div
        c3p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (d_tag[k]),
            .i_dat   (d_dat[k]),
            .o_tag   (d_tag[k+1]),
            .o_dat   (d_dat[k+1])
        );
    end

    always_comb begin
        w_cx        = sat_cen(d_dat[QB].qx, d_tag[QB].negx, d_tag[QB].ovfx);
        w_cy        = sat_cen(d_dat[QB].qy, d_tag[QB].negy, d_tag[QB].ovfy);
        n_p1.valid  = d_tag[QB].valid;
        n_p1.colin  = d_tag[QB].colin;
        n_p1.sat    = w_cx[CW] | w_cy[CW];
        n_p1.big    = d_tag[QB].ovfx | d_tag[QB].ovfy;
        n_p1.cx     = w_cx[CW-1:0];
        n_p1.cy     = w_cy[CW-1:0];
        w_mx        = mag_of(r_p1_dx);
        w_my        = mag_of(r_p1_dy);
        n_p2        = r_p1;
        n_p2.big    = r_p1.big | w_mx[MAGW] | w_my[MAGW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.valid <= 1'b0;
            r_p2.valid <= 1'b0;
            r_p3.valid <= 1'b0;
        end else if (w_en) begin
            r_p1     <= n_p1;
            r_p2     <= n_p2;
            r_p3     <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_dx <= delta(d_tag[QB].x1, d_dat[QB].qx, d_tag[QB].negx);
            r_p1_dy <= delta(d_tag[QB].y1, d_dat[QB].qy, d_tag[QB].negy);
            r_p2_sx <= w_mx[MAGW-1:0] * w_mx[MAGW-1:0];
            r_p2_sy <= w_my[MAGW-1:0] * w_my[MAGW-1:0];
            r_p3_v  <= RADW'(r_p2_sx) + RADW'(r_p2_sy);
        end
    end

    assign s_tag[0] = r_p3;
    assign s_dat[0] = '{rad: r_p3_v, rem: '0, root: '0};

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        c3p_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (s_tag[k]),
            .i_dat   (s_dat[k]),
            .o_tag   (s_tag[k+1]),
            .o_dat   (s_dat[k+1])
        );
    end

    assign w_big = s_tag[RTW].big | s_dat[RTW].root[RTW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= s_tag[RTW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (s_tag[RTW].colin) begin
                r_cx  <= '0;
                r_cy  <= '0;
                r_rad <= '0;
                r_st  <= ST_COLIN;
            end else begin
                r_cx  <= s_tag[RTW].cx;
                r_cy  <= s_tag[RTW].cy;
                r_rad <= w_big ? '1 : s_dat[RTW].root[MAGW-1:0];
                r_st  <= (w_big || s_tag[RTW].sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_centre_x = r_cx;
    assign o_centre_y = r_cy;
    assign o_radius   = r_rad;
    assign o_status   = r_st;

endmodule
`default_nettype wire

// ----- hdl/c3p_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// c3p_checker: port level checks of the circumcircle block
// Reset, hold under stall, collinear words and the input stall.
// ----------------------------------------------------------------------------
module c3p_checker import c3p_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_stall,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire logic signed [CW-1:0] o_centre_x,
    input wire logic signed [CW-1:0] o_centre_y,
    input wire logic [MAGW-1:0]      o_radius,
    input wire logic [1:0]           o_status
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_centre_x) && $stable(o_centre_y)
            && $stable(o_radius) && $stable(o_status))
        else $error("stalled output word changed");

    a_colin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_COLIN) |-> (o_centre_x == '0) && (o_centre_y == '0)
            && (o_radius == '0))
        else $error("collinear word with nonzero circle");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output word blocked");

endmodule

bind circle_through_three_points c3p_checker u_c3p_checker (.*);
`default_nettype wire

// ----- sim/tb_circle_through_three_points.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_through_three_points: self-checking bench for the circumcircle block
// Walks a table of directed point triples, then random triples of several
// shapes, under random idling on both sides. Each word out is compared
// field by field with an exact wide-integer circumcircle or a given collinear one.
// ----------------------------------------------------------------------------
module tb_circle_through_three_points;
    import c3p_pkg::*;

    typedef logic signed [319:0] t_wide;
    typedef logic [319:0]        t_uwide;

    typedef struct packed {
        logic [CW-1:0]   cx;
        logic [CW-1:0]   cy;
        logic [MAGW-1:0] rad;
        t_status         st;
    } t_circle;

    typedef struct packed {
        logic [CW-1:0] x1, y1, x2, y2, x3, y3;
        logic          typed;
        t_circle       want;
    } t_row;

    localparam int    N_RAND = 1800;
    localparam t_wide CMAX   = 320'sd2147483647;
    localparam t_wide CMIN   = -320'sd2147483648;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_first_x, i_first_y, i_second_x, i_second_y, i_third_x, i_third_y;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CW-1:0] o_centre_x, o_centre_y;
    logic [MAGW-1:0]      o_radius;
    logic [1:0]           o_status;

    t_circle circle_q[$];
    t_row    dir_rows[$];
    int      n_err;
    bit      quiet;
    bit      hold_req;

    circle_through_three_points uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_first_x(i_first_x), .i_first_y(i_first_y),
        .i_second_x(i_second_x), .i_second_y(i_second_y),
        .i_third_x(i_third_x), .i_third_y(i_third_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_centre_x(o_centre_x), .o_centre_y(o_centre_y),
        .o_radius(o_radius), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_circle circumcircle(input logic [CW-1:0] a1, b1, a2, b2, a3, b3);
        t_wide   x1, y1, x2, y2, x3, y3, t1, t2, t3, s1, s2, s3, d, nx, ny, cx, cy, dx, dy;
        t_uwide  rsq, root, cand;
        t_circle r;
        logic    sat;
        x1 = $signed(a1); y1 = $signed(b1);
        x2 = $signed(a2); y2 = $signed(b2);
        x3 = $signed(a3); y3 = $signed(b3);
        t1 = y2 - y3; t2 = y3 - y1; t3 = y1 - y2;
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        d  = 2 * (x1 * t1 + x2 * t2 + x3 * t3);
        if (d == 0) begin
            r = '{cx: '0, cy: '0, rad: '0, st: ST_COLIN};
            return r;
        end
        nx = s1 * t1 + s2 * t2 + s3 * t3;
        ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
        cx = nx / d;
        cy = ny / d;
        dx = x1 - cx;
        dy = y1 - cy;
        rsq = t_uwide'(dx * dx + dy * dy);
        root = '0;
        for (int k = 159; k >= 0; k--) begin
            cand = root | (t_uwide'(1) << k);
            if (cand * cand <= rsq) root = cand;
        end
        sat = 1'b0;
        if (cx > CMAX) begin r.cx = CMAX[CW-1:0]; sat = 1'b1; end
        else if (cx < CMIN) begin r.cx = CMIN[CW-1:0]; sat = 1'b1; end
        else r.cx = cx[CW-1:0];
        if (cy > CMAX) begin r.cy = CMAX[CW-1:0]; sat = 1'b1; end
        else if (cy < CMIN) begin r.cy = CMIN[CW-1:0]; sat = 1'b1; end
        else r.cy = cy[CW-1:0];
        if (root > t_uwide'(CMAX)) begin r.rad = '1; sat = 1'b1; end
        else r.rad = root[MAGW-1:0];
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic t_row mk_row(input logic [CW-1:0] a1, b1, a2, b2, a3, b3,
                                    input logic typed, input t_circle want);
        t_row r;
        r = '{x1: a1, y1: b1, x2: a2, y2: b2, x3: a3, y3: b3, typed: typed, want: want};
        return r;
    endfunction

    task automatic report(input string what, input logic [CW-1:0] got, input logic [CW-1:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        n_err++;
    endtask

    task automatic send_word(input t_row r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_first_x  <= r.x1; i_first_y  <= r.y1;
        i_second_x <= r.x2; i_second_y <= r.y2;
        i_third_x  <= r.x3; i_third_y  <= r.y3;
        do @(posedge i_clk); while (o_stall);
        circle_q.push_back(r.typed ? r.want
                                   : circumcircle(r.x1, r.y1, r.x2, r.y2, r.x3, r.y3));
    endtask

    function automatic logic [CW-1:0] rnd_coord(input int shape);
        logic [CW-1:0] v;
        v = $urandom;
        case (shape)
            0: return $signed(v) >>> $urandom_range(8, 28);
            1: return v;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return '0;
                    default: return v;
                endcase
            end
        endcase
    endfunction

    function automatic t_row rnd_row();
        int            kind, k;
        logic [CW-1:0] c[6];
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++) begin
            c[i] = rnd_coord(kind < 4 ? 0 : (kind < 6 ? 1 : (kind == 9 ? 2 : 0)));
        end
        if (kind == 6 || kind == 8) begin
            k    = $urandom_range(0, 6) - 3;
            c[4] = $signed(c[0]) + k * ($signed(c[2]) - $signed(c[0]));
            c[5] = $signed(c[1]) + k * ($signed(c[3]) - $signed(c[1]));
            if (kind == 8) c[$urandom_range(4, 5)] += $urandom_range(0, 1) ? 1 : -1;
        end else if (kind == 7) begin
            c[2] = c[0];
            c[3] = c[1];
        end
        return mk_row(c[0], c[1], c[2], c[3], c[4], c[5], 1'b0, '0);
    endfunction

    always @(posedge i_clk) begin
        t_circle w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (circle_q.size() == 0) begin
                report("unexpected word", o_centre_x, '0);
            end else begin
                w = circle_q.pop_front();
                if (o_centre_x !== w.cx) report("centre_x", o_centre_x, w.cx);
                if (o_centre_y !== w.cy) report("centre_y", o_centre_y, w.cy);
                if (o_radius !== w.rad) report("radius", CW'(o_radius), CW'(w.rad));
                if (o_status !== w.st) report("status", CW'(o_status), CW'(w.st));
            end
        end
    end

    // receiver: random stall before each word, one long hold on request
    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 9);
                if (n != 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid && !hold_req);
        end
    end

    initial begin
        t_circle colin;
        n_err    = 0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        colin    = '{cx: '0, cy: '0, rad: '0, st: ST_COLIN};
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_first_x  <= '0; i_first_y  <= '0;
        i_second_x <= '0; i_second_y <= '0;
        i_third_x  <= '0; i_third_y  <= '0;

        dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1'b1, colin));
        dir_rows.push_back(mk_row(32'h10000, 32'h20000, 32'h10000, 32'h20000, 5, 7, 1'b1, colin));
        dir_rows.push_back(mk_row(0, 0, 32'h10000, 32'h10000, 32'h30000, 32'h30000, 1'b1, colin));
        dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h7fffffff, 1'b1, colin));
        dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff, 1'b1, colin));
        dir_rows.push_back(mk_row(0, 0, 32'h20000, 0, 0, 32'h20000, 1'b0, '0));
        dir_rows.push_back(mk_row(32'hffff0000, 0, 32'h10000, 0, 0, 32'h10000, 1'b0, '0));
        dir_rows.push_back(mk_row(0, 0, 1, 0, 0, 1, 1'b0, '0));
        dir_rows.push_back(mk_row(0, 0, 1, 0, 32'h7fffffff, 1, 1'b0, '0));
        dir_rows.push_back(mk_row(0, 0, 32'hffffffff, 0, 32'h80000000, 1, 1'b0, '0));
        dir_rows.push_back(mk_row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h80000000, 32'h80000000, 1'b0, '0));
        dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                  32'h7fffffff, 32'h80000000, 1'b0, '0));
        dir_rows.push_back(mk_row(32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 1'b0, '0));
        dir_rows.push_back(mk_row(0, 0, 32'h7fffffff, 1, 32'h80000000, 32'h7fffffff, 1'b0, '0));
        dir_rows.push_back(mk_row(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321,
                                  32'h55555555, 32'haaaaaaaa, 1'b0, '0));
        dir_rows.push_back(mk_row(32'haaaaaaaa, 32'h55555555, 32'hffffffff, 32'h00000001,
                                  32'h00000000, 32'hfffffffe, 1'b0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_word(dir_rows[i]);
        for (int i = 0; i < N_RAND; i++) begin
            if (i == 300) hold_req = 1'b1;
            quiet = (i >= 600 && i < 800);
            if (i == 1000) begin
                i_valid <= 1'b0;
                wait (circle_q.size() == 0);
                @(posedge i_clk);
            end
            send_word(rnd_row());
        end
        i_valid <= 1'b0;
        wait (circle_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/c3p_pkg.sv
hdl/c3p_front.sv
hdl/c3p_div_cell.sv
hdl/c3p_sqrt_cell.sv
hdl/circle_through_three_points.sv
hdl/c3p_checker.sv
sim/tb_circle_through_three_points.sv
